// ===== hw/rtl/buffer_ring_fill_manager_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the buffer ring fill manager
// Shorthand for clocked concurrent checks, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef BUFFER_RING_FILL_MANAGER_CORE_ASSERT_SVH
`define BUFFER_RING_FILL_MANAGER_CORE_ASSERT_SVH

// Check sampled on clk, skipped while rst_n is low.
`define BRFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check sampled on clk with no reset gating.
`define BRFM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/brfm_pkg.sv =====
// ----------------------------------------------------------------------------
// brfm_pkg
// Shared sizes, codes and structs of the buffer ring fill manager.
// ----------------------------------------------------------------------------
package brfm_pkg;

  localparam int BUFFERS = 4;
  localparam int IDX_W   = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
  localparam int CNT_W   = $clog2(BUFFERS + 1);
  localparam int NUM_W   = 4;
  localparam int CMP_W   = NUM_W + 1;
  localparam int DATA_W  = 32;
  localparam int ENT_W   = 2 * DATA_W;

  typedef enum logic [2:0] {
    CMD_REGISTER = 3'd0,
    CMD_APPEND   = 3'd1,
    CMD_MARK     = 3'd2,
    CMD_SNAPSHOT = 3'd3,
    CMD_CLEAR    = 3'd4,
    CMD_QUERY    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_NO_ROOM   = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_REWRITTEN = 3'd4,
    ST_DUPLICATE = 3'd5
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [NUM_W-1:0]  num;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] len;
    logic              adv;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  slot;
    logic [DATA_W-1:0] fill;
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_t;

  typedef struct packed {
    status_t           status;
    logic              ready;
    logic [NUM_W-1:0]  index;
    logic [DATA_W-1:0] fill;
    logic [DATA_W-1:0] waddr;
    logic [DATA_W-1:0] free;
  } result_t;

endpackage

// ===== hw/rtl/brfm_ram.sv =====
// ----------------------------------------------------------------------------
// brfm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module brfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hw/rtl/brfm_exec.sv =====
// ----------------------------------------------------------------------------
// brfm_exec
// Command decode and next-state logic for one item, purely combinational.
// ----------------------------------------------------------------------------
module brfm_exec (
  input  brfm_pkg::item_t   item,
  input  brfm_pkg::state_t  st,
  input  brfm_pkg::entry_t  ent_slot,
  input  brfm_pkg::entry_t  ent_num,
  output brfm_pkg::state_t  st_nxt,
  output brfm_pkg::wr_t     wr,
  output brfm_pkg::result_t res
);

  logic                          slot_ok;
  logic                          ready;
  logic [brfm_pkg::DATA_W-1:0]   base;
  logic [brfm_pkg::DATA_W-1:0]   sz;
  logic [brfm_pkg::DATA_W-1:0]   free;
  logic [brfm_pkg::DATA_W-1:0]   waddr;
  logic [brfm_pkg::CMP_W-1:0]    num_w;
  logic [brfm_pkg::CMP_W-1:0]    cnt_w;
  logic                          snap;
  brfm_pkg::status_t             status;
  logic [brfm_pkg::IDX_W-1:0]    slot_inc;

  always_comb begin
    // entries at or above the count were never written since reset or clear
    slot_ok = brfm_pkg::CMP_W'(st.slot) < brfm_pkg::CMP_W'(st.count);
    base    = slot_ok ? ent_slot.base : '0;
    sz      = slot_ok ? ent_slot.size : '0;
    free    = (sz > st.fill) ? (sz - st.fill) : '0;
    waddr   = base + st.fill;
    ready   = (st.count == brfm_pkg::CNT_W'(brfm_pkg::BUFFERS));
    num_w   = {1'b0, item.num};
    cnt_w   = brfm_pkg::CMP_W'(st.count);
    slot_inc = (st.slot == brfm_pkg::IDX_W'(brfm_pkg::BUFFERS - 1)) ? '0
               : st.slot + 1'b1;

    st_nxt       = st;
    wr.en        = 1'b0;
    wr.addr      = item.num[brfm_pkg::IDX_W-1:0];
    wr.data.base = item.addr;
    wr.data.size = item.size;
    status       = brfm_pkg::ST_OK;
    snap         = 1'b0;

    case (item.cmd)
      brfm_pkg::CMD_REGISTER: begin
        if (num_w >= brfm_pkg::CMP_W'(brfm_pkg::BUFFERS) || num_w > cnt_w) begin
          status = brfm_pkg::ST_BAD_INDEX;
        end else if (num_w == cnt_w) begin
          wr.en        = 1'b1;
          st_nxt.count = st.count + 1'b1;
        end else if (ent_num.base != item.addr || ent_num.size != item.size) begin
          wr.en  = 1'b1;
          status = brfm_pkg::ST_REWRITTEN;
        end else begin
          status = brfm_pkg::ST_DUPLICATE;
        end
      end
      brfm_pkg::CMD_APPEND: begin
        if (!ready) begin
          status = brfm_pkg::ST_NOT_READY;
        end else if (item.len > free) begin
          status = brfm_pkg::ST_NO_ROOM;
        end else begin
          st_nxt.fill = st.fill + item.len;
        end
      end
      brfm_pkg::CMD_MARK: begin
        if (item.len > free) begin
          status = brfm_pkg::ST_NO_ROOM;
        end else begin
          st_nxt.fill = st.fill + item.len;
        end
      end
      brfm_pkg::CMD_SNAPSHOT: begin
        if (!ready) begin
          status = brfm_pkg::ST_NOT_READY;
        end else begin
          snap        = 1'b1;
          st_nxt.fill = '0;
          if (item.adv) begin
            st_nxt.slot = slot_inc;
          end
        end
      end
      brfm_pkg::CMD_CLEAR: begin
        st_nxt = '0;
      end
      brfm_pkg::CMD_QUERY: begin
        if (!ready) begin
          status = brfm_pkg::ST_NOT_READY;
        end
      end
      default: begin
        status = brfm_pkg::ST_BAD_INDEX;
      end
    endcase

    res.status = status;
    res.ready  = (st_nxt.count == brfm_pkg::CNT_W'(brfm_pkg::BUFFERS));
    res.index  = snap ? brfm_pkg::NUM_W'(st.slot) : brfm_pkg::NUM_W'(st_nxt.slot);
    res.fill   = snap ? st.fill : st_nxt.fill;
    res.waddr  = waddr;
    res.free   = free;
  end

endmodule

// ===== hw/rtl/buffer_ring_fill_manager_core.sv =====
// ----------------------------------------------------------------------------
// buffer_ring_fill_manager_core
// Ring of registered memory buffers with append, fill and snapshot commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one command item per cycle
//   while in_stall is low: register buffer, append, mark filled, snapshot,
//   clear or query. Result channel (out_valid / out_stall) returns exactly
//   one result item per command, in command order.
//   Path: an accepted item passes through the input register, then the
//   result register, whose contents out_valid flags. Throughput: 1 item per
//   cycle while the receiver does not stall; the limit is the single pass
//   through the decode/add/compare logic between those two registers.
//   The buffer table sits in a small two-read-port RAM read at accept time;
//   a write from the item ahead is forwarded into the read.
//   Reset (rst_n low, synchronous) empties both pipeline stages and clears
//   count, slot and fill; table entries at or above the count read as zero,
//   so no clearing pass is needed and the block takes items right after reset.
//   When the receiver stalls, the result is held in the output register and
//   one more item may still enter the input register; in_stall rises only
//   when both are full.
// ----------------------------------------------------------------------------
`include "buffer_ring_fill_manager_core_assert.svh"

module buffer_ring_fill_manager_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_command,
  input  logic [brfm_pkg::NUM_W-1:0]  in_buffer_number,
  input  logic [brfm_pkg::DATA_W-1:0] in_buffer_address,
  input  logic [brfm_pkg::DATA_W-1:0] in_buffer_size,
  input  logic [brfm_pkg::DATA_W-1:0] in_length,
  input  logic                        in_may_advance,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_status,
  output logic                        out_ready_res,
  output logic [brfm_pkg::NUM_W-1:0]  out_buffer_index,
  output logic [brfm_pkg::DATA_W-1:0] out_fill_level,
  output logic [brfm_pkg::DATA_W-1:0] out_write_address,
  output logic [brfm_pkg::DATA_W-1:0] out_free_space
);

  // pipeline control
  logic                       s1_v_r, s1_v_nxt;
  logic                       out_v_r, out_v_nxt;
  logic                       accept;
  logic                       out_load;

  // input register and architectural state
  brfm_pkg::item_t            item_r;
  brfm_pkg::state_t           state_r;
  brfm_pkg::state_t           state_nxt;
  brfm_pkg::result_t          res_r;
  brfm_pkg::result_t          res_nxt;
  brfm_pkg::wr_t              wr;

  // table RAM and forwarding
  logic                       ram_we;
  logic [brfm_pkg::IDX_W-1:0] raddr_a;
  logic [brfm_pkg::IDX_W-1:0] raddr_b;
  logic [brfm_pkg::ENT_W-1:0] q_a;
  logic [brfm_pkg::ENT_W-1:0] q_b;
  logic                       byp_a_r;
  logic                       byp_b_r;
  brfm_pkg::entry_t           byp_data_r;
  brfm_pkg::entry_t           ent_slot;
  brfm_pkg::entry_t           ent_num;

  // result register loads when stage 1 holds an item and the output is free
  assign out_load = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && !out_load;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (out_load) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      if (out_load) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cmd  <= brfm_pkg::cmd_t'(in_command);
      item_r.num  <= in_buffer_number;
      item_r.addr <= in_buffer_address;
      item_r.size <= in_buffer_size;
      item_r.len  <= in_length;
      item_r.adv  <= in_may_advance;
      // a write at the same edge lands after the RAM read; forward it
      byp_a_r     <= ram_we && (wr.addr == raddr_a);
      byp_b_r     <= ram_we && (wr.addr == raddr_b);
      byp_data_r  <= wr.data;
    end
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  // read at accept: the slot as it stands after the item ahead completes
  assign ram_we  = out_load && wr.en;
  assign raddr_a = out_load ? state_nxt.slot : state_r.slot;
  assign raddr_b = in_buffer_number[brfm_pkg::IDX_W-1:0];

  brfm_ram #(
    .WIDTH (brfm_pkg::ENT_W),
    .DEPTH (brfm_pkg::BUFFERS)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wr.addr),
    .wdata   (wr.data),
    .re      (accept),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (q_a),
    .rdata_b (q_b)
  );

  assign ent_slot = byp_a_r ? byp_data_r : brfm_pkg::entry_t'(q_a);
  assign ent_num  = byp_b_r ? byp_data_r : brfm_pkg::entry_t'(q_b);

  brfm_exec u_exec (
    .item     (item_r),
    .st       (state_r),
    .ent_slot (ent_slot),
    .ent_num  (ent_num),
    .st_nxt   (state_nxt),
    .wr       (wr),
    .res      (res_nxt)
  );

  assign out_valid         = out_v_r;
  assign out_status        = res_r.status;
  assign out_ready_res     = res_r.ready;
  assign out_buffer_index  = res_r.index;
  assign out_fill_level    = res_r.fill;
  assign out_write_address = res_r.waddr;
  assign out_free_space    = res_r.free;

  // checks
  `BRFM_ASSERT(a_count_bound,
    state_r.count <= brfm_pkg::CNT_W'(brfm_pkg::BUFFERS),
    "registered count above buffer count")
  `BRFM_ASSERT(a_slot_bound,
    brfm_pkg::CMP_W'(state_r.slot) < brfm_pkg::CMP_W'(brfm_pkg::BUFFERS),
    "current slot outside ring")
  `BRFM_ASSERT(a_state_hold,
    !out_load |=> $stable(state_r),
    "state changed with no item completing")
  `BRFM_ASSERT(a_snap_clears,
    (out_load && item_r.cmd == brfm_pkg::CMD_SNAPSHOT
     && res_nxt.status == brfm_pkg::ST_OK) |=> (state_r.fill == '0),
    "snapshot left fill nonzero")

endmodule

// ===== tb/sv/tb_buffer_ring_fill_manager_core.sv =====
// ----------------------------------------------------------------------------
// tb_buffer_ring_fill_manager_core
// Self-checking bench: a short directed table, then constrained-by-hand random
// commands, each result checked against an in-bench ring model or typed status.
// ----------------------------------------------------------------------------
module tb_buffer_ring_fill_manager_core;
  timeunit 1ns;
  timeprecision 1ps;

  import brfm_pkg::*;

  // Command codes the package enum does not cover; the block must refuse them.
  localparam logic [2:0] CMD_UNUSED6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED7 = 3'd7;

  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_CYCLES  = 64;   // long receiver hold-off, fills the pipe

  // One command item plus, for directed rows, a hand-written status.
  // Typed rows expect every other result field at zero.
  typedef struct packed {
    logic [2:0]        cmd;
    logic [NUM_W-1:0]  num;
    logic [DATA_W-1:0] addr;
    logic [DATA_W-1:0] size;
    logic [DATA_W-1:0] len;
    logic              adv;
    logic              typed;
    status_t           want_status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic              in_valid;
  logic              in_stall;
  logic [2:0]        in_command;
  logic [NUM_W-1:0]  in_buffer_number;
  logic [DATA_W-1:0] in_buffer_address;
  logic [DATA_W-1:0] in_buffer_size;
  logic [DATA_W-1:0] in_length;
  logic              in_may_advance;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        out_status;
  logic              out_ready_res;
  logic [NUM_W-1:0]  out_buffer_index;
  logic [DATA_W-1:0] out_fill_level;
  logic [DATA_W-1:0] out_write_address;
  logic [DATA_W-1:0] out_free_space;

  // Model of the ring: tables, registration count, current slot, fill.
  logic [DATA_W-1:0] ring_base [BUFFERS];
  logic [DATA_W-1:0] ring_size [BUFFERS];
  logic [CNT_W-1:0]  ring_count;
  logic [IDX_W-1:0]  ring_slot;
  logic [DATA_W-1:0] ring_fill;

  result_t   awaited_results [$];
  stim_row_t directed_rows [$];
  int        mismatch_count = 0;
  logic      hold_request = 1'b0;

  buffer_ring_fill_manager_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_buffer_number  (in_buffer_number),
    .in_buffer_address (in_buffer_address),
    .in_buffer_size    (in_buffer_size),
    .in_length         (in_length),
    .in_may_advance    (in_may_advance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_ready_res     (out_ready_res),
    .out_buffer_index  (out_buffer_index),
    .out_fill_level    (out_fill_level),
    .out_write_address (out_write_address),
    .out_free_space    (out_free_space)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Ring model. Called once per accepted item, in acceptance order.
  // Write address and free space always describe the state before the
  // command; a snapshot reports the old slot and fill instead of the new ones.
  // --------------------------------------------------------------------------
  function automatic result_t apply_ring_command(input stim_row_t it);
    result_t           r;
    logic [IDX_W-1:0]  s;
    logic [DATA_W-1:0] free_sp;
    logic [DATA_W-1:0] old_fill;
    logic              snap;
    int                next_slot;
    int                i;
    s        = ring_slot;
    free_sp  = (ring_size[s] > ring_fill) ? ring_size[s] - ring_fill : '0;
    old_fill = ring_fill;
    snap     = 1'b0;
    r        = '0;
    r.waddr  = ring_base[s] + ring_fill;   // wraps mod 2^32
    r.free   = free_sp;
    r.status = ST_OK;
    case (it.cmd)
      CMD_REGISTER: begin
        // Strictly in order: next free number registers, lower ones rewrite.
        if (it.num >= BUFFERS || it.num > ring_count) begin
          r.status = ST_BAD_INDEX;
        end else if (it.num == ring_count) begin
          ring_base[it.num[IDX_W-1:0]] = it.addr;
          ring_size[it.num[IDX_W-1:0]] = it.size;
          ring_count++;
        end else if (ring_base[it.num[IDX_W-1:0]] != it.addr ||
                     ring_size[it.num[IDX_W-1:0]] != it.size) begin
          ring_base[it.num[IDX_W-1:0]] = it.addr;
          ring_size[it.num[IDX_W-1:0]] = it.size;
          r.status = ST_REWRITTEN;
        end else begin
          r.status = ST_DUPLICATE;
        end
      end
      CMD_APPEND: begin
        if (ring_count != BUFFERS) r.status = ST_NOT_READY;
        else if (it.len > free_sp) r.status = ST_NO_ROOM;
        else ring_fill = ring_fill + it.len;
      end
      CMD_MARK: begin
        // No readiness check: uses whatever the current slot's entry holds.
        if (it.len > free_sp) r.status = ST_NO_ROOM;
        else ring_fill = ring_fill + it.len;
      end
      CMD_SNAPSHOT: begin
        if (ring_count != BUFFERS) begin
          r.status = ST_NOT_READY;
        end else begin
          snap = 1'b1;
          if (it.adv) begin
            next_slot = (int'(s) + 1) % BUFFERS;
            ring_slot = next_slot[IDX_W-1:0];
          end
          ring_fill = '0;
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < BUFFERS; i++) begin
          ring_base[i] = '0;
          ring_size[i] = '0;
        end
        ring_count = '0;
        ring_slot  = '0;
        ring_fill  = '0;
      end
      CMD_QUERY: begin
        if (ring_count != BUFFERS) r.status = ST_NOT_READY;
      end
      default: r.status = ST_BAD_INDEX;
    endcase
    r.ready = (ring_count == BUFFERS);
    r.index = snap ? NUM_W'(s) : NUM_W'(ring_slot);
    r.fill  = snap ? old_fill : ring_fill;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void add_row(input logic [2:0] cmd, input logic [NUM_W-1:0] num,
                                  input logic [DATA_W-1:0] addr, input logic [DATA_W-1:0] size,
                                  input logic [DATA_W-1:0] len, input logic adv,
                                  input logic typed, input status_t want_status);
    stim_row_t row;
    row = '{cmd, num, addr, size, len, adv, typed, want_status};
    directed_rows.push_back(row);
  endfunction

  // Sender gap: mostly back-to-back, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Lengths cluster around the free space so both room and no-room are hit.
  function automatic logic [DATA_W-1:0] pick_length(input logic [DATA_W-1:0] free_sp);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return (free_sp == 0) ? '0 : $urandom_range(0, free_sp);
    if (r < 60) return free_sp;
    if (r < 75) return free_sp + 1;
    return $urandom;
  endfunction

  // Mostly small buffers so fills and snapshots cycle; some full-range.
  function automatic logic [DATA_W-1:0] pick_size();
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 512);
    return $urandom;
  endfunction

  // Random command shaped from the model state: before ready, mostly the
  // next in-order registration; once ready, the working command mix.
  function automatic stim_row_t make_random_row();
    stim_row_t         it;
    int                r;
    logic [IDX_W-1:0]  s;
    logic [DATA_W-1:0] free_sp;
    s       = ring_slot;
    free_sp = (ring_size[s] > ring_fill) ? ring_size[s] - ring_fill : '0;
    it.num  = NUM_W'($urandom);
    it.addr = $urandom;
    it.size = pick_size();
    it.len  = $urandom;
    it.adv  = 1'($urandom_range(0, 1));
    it.typed       = 1'b0;
    it.want_status = ST_OK;
    r = $urandom_range(0, 99);
    if (ring_count < BUFFERS && r < 65) begin
      it.cmd = CMD_REGISTER;
      it.num = (r < 55) ? NUM_W'(ring_count) : NUM_W'($urandom_range(0, 15));
      return it;
    end
    r = $urandom_range(0, 99);
    if (r < 12) begin
      it.cmd = CMD_REGISTER;
      if (ring_count > 0 && $urandom_range(0, 2) != 0) begin
        it.num = NUM_W'($urandom_range(0, ring_count - 1));
        // half of the re-registrations repeat the entry exactly
        if ($urandom_range(0, 1) != 0) begin
          it.addr = ring_base[it.num[IDX_W-1:0]];
          it.size = ring_size[it.num[IDX_W-1:0]];
        end
      end else begin
        it.num = NUM_W'($urandom_range(0, 15));
      end
    end else if (r < 40) begin
      it.cmd = CMD_APPEND;
      it.len = pick_length(free_sp);
    end else if (r < 58) begin
      it.cmd = CMD_MARK;
      it.len = pick_length(free_sp);
    end else if (r < 76) begin
      it.cmd = CMD_SNAPSHOT;
    end else if (r < 89) begin
      it.cmd = CMD_QUERY;
    end else if (r < 93) begin
      it.cmd = CMD_CLEAR;
    end else begin
      it.cmd = ($urandom_range(0, 1) != 0) ? CMD_UNUSED6 : CMD_UNUSED7;
    end
    return it;
  endfunction

  // Present one item at the falling edge, hold it until accepted, then
  // record what the ring should answer.
  task automatic send_row(input stim_row_t it);
    result_t want;
    @(negedge clk);
    in_command        = it.cmd;
    in_buffer_number  = it.num;
    in_buffer_address = it.addr;
    in_buffer_size    = it.size;
    in_length         = it.len;
    in_may_advance    = it.adv;
    in_valid          = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = apply_ring_command(it);
    if (it.typed) begin
      want        = '0;
      want.status = it.want_status;
    end
    awaited_results.push_back(want);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $time);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        note_mismatch("unexpected result, status", DATA_W'(out_status), '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status)
          note_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
        if (out_ready_res !== want.ready)
          note_mismatch("ready_res", DATA_W'(out_ready_res), DATA_W'(want.ready));
        if (out_buffer_index !== want.index)
          note_mismatch("buffer_index", DATA_W'(out_buffer_index), DATA_W'(want.index));
        if (out_fill_level !== want.fill)
          note_mismatch("fill_level", out_fill_level, want.fill);
        if (out_write_address !== want.waddr)
          note_mismatch("write_address", out_write_address, want.waddr);
        if (out_free_space !== want.free)
          note_mismatch("free_space", out_free_space, want.free);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: alternating free and stalled runs, plus one long hold-off on
  // request so the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int   run_left;
    int   k;
    logic stalling;
    out_stall = 1'b0;
    run_left  = 0;
    stalling  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall    = 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
      end
      if (run_left == 0) begin
        stalling = !stalling;
        if (stalling)
          run_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        else
          run_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(40, 120);
      end
      out_stall = stalling;
      run_left--;
    end
  end

  // Watchdog: far beyond the slowest legal run (~0.8 ms).
  initial begin : watchdog
    #5_000_000;
    $display("buffer_ring_fill_manager_core verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    int burst_left;
    in_valid          = 1'b0;
    in_command        = '0;
    in_buffer_number  = '0;
    in_buffer_address = '0;
    in_buffer_size    = '0;
    in_length         = '0;
    in_may_advance    = 1'b0;
    burst_left        = 0;
    for (n = 0; n < BUFFERS; n++) begin
      ring_base[n] = '0;
      ring_size[n] = '0;
    end
    ring_count = '0;
    ring_slot  = '0;
    ring_fill  = '0;

    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed table. Typed rows: state still empty, answer is status alone.
    //      cmd           num    addr           size           len            adv   typed status
    add_row(CMD_QUERY,    4'd0,  32'h0,         32'h0,         32'h0,         1'b0, 1'b1, ST_NOT_READY);
    add_row(CMD_APPEND,   4'd0,  32'h0,         32'h0,         32'hFFFF_FFFF, 1'b0, 1'b1, ST_NOT_READY);
    add_row(CMD_SNAPSHOT, 4'd0,  32'h0,         32'h0,         32'h0,         1'b1, 1'b1, ST_NOT_READY);
    add_row(CMD_MARK,     4'd0,  32'h0,         32'h0,         32'h0,         1'b0, 1'b1, ST_OK);
    add_row(CMD_MARK,     4'd0,  32'h0,         32'h0,         32'h1,         1'b0, 1'b1, ST_NO_ROOM);
    add_row(CMD_REGISTER, 4'd1,  32'h0,         32'h0,         32'h0,         1'b0, 1'b1, ST_BAD_INDEX);
    add_row(CMD_REGISTER, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,         1'b1, 1'b1, ST_BAD_INDEX);
    // registration order, duplicate, rewrite; mark allowed before ready
    add_row(CMD_REGISTER, 4'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, ST_OK);
    add_row(CMD_REGISTER, 4'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, ST_OK);
    add_row(CMD_REGISTER, 4'd0,  32'h0000_1000, 32'h0000_0100, 32'h0,         1'b0, 1'b0, ST_OK);
    add_row(CMD_MARK,     4'd0,  32'h0,         32'h0,         32'h10,        1'b0, 1'b0, ST_OK);
    add_row(CMD_REGISTER, 4'd1,  32'h0000_2000, 32'h0,         32'h0,         1'b0, 1'b0, ST_OK);
    add_row(CMD_REGISTER, 4'd2,  32'hFFFF_FFF0, 32'h0000_0040, 32'h0,         1'b0, 1'b0, ST_OK);
    add_row(CMD_REGISTER, 4'd3,  32'h0,         32'hFFFF_FFFF, 32'h0,         1'b0, 1'b0, ST_OK);
    // ready: exact fit, one byte over, snapshots with and without advance
    add_row(CMD_APPEND,   4'd0,  32'h0,         32'h0,         32'hF0,        1'b0, 1'b0, ST_OK);
    add_row(CMD_APPEND,   4'd0,  32'h0,         32'h0,         32'h1,         1'b0, 1'b0, ST_OK);
    add_row(CMD_SNAPSHOT, 4'd0,  32'h0,         32'h0,         32'h0,         1'b1, 1'b0, ST_OK);
    add_row(CMD_SNAPSHOT, 4'd0,  32'h0,         32'h0,         32'h0,         1'b0, 1'b0, ST_OK);
    add_row(CMD_SNAPSHOT, 4'd0,  32'h0,         32'h0,         32'h0,         1'b1, 1'b0, ST_OK);
    // slot near the top of memory; shrink it below its fill -> free clamps
    add_row(CMD_APPEND,   4'd0,  32'h0,         32'h0,         32'h20,        1'b0, 1'b0, ST_OK);
    add_row(CMD_REGISTER, 4'd2,  32'hFFFF_FFF0, 32'h0000_0010, 32'h0,         1'b0, 1'b0, ST_OK);
    add_row(CMD_QUERY,    4'd0,  32'h0,         32'h0,         32'h0,         1'b0, 1'b0, ST_OK);
    add_row(CMD_UNUSED6,  4'd0,  32'h0,         32'h0,         32'h0,         1'b0, 1'b0, ST_OK);
    add_row(CMD_UNUSED7,  4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_OK);
    // full-size slot takes the largest append; last advance wraps to slot 0
    add_row(CMD_SNAPSHOT, 4'd0,  32'h0,         32'h0,         32'h0,         1'b1, 1'b0, ST_OK);
    add_row(CMD_APPEND,   4'd0,  32'h0,         32'h0,         32'hFFFF_FFFF, 1'b0, 1'b0, ST_OK);
    add_row(CMD_SNAPSHOT, 4'd0,  32'h0,         32'h0,         32'h0,         1'b1, 1'b0, ST_OK);
    add_row(CMD_CLEAR,    4'd0,  32'h0,         32'h0,         32'h0,         1'b0, 1'b0, ST_OK);

    foreach (directed_rows[i]) begin
      idle_sender(pick_gap());
      send_row(directed_rows[i]);
    end

    // Random phase
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        // receiver holds off while the sender keeps pushing back-to-back
        hold_request = 1'b1;
        burst_left   = 40;
      end
      if (n == 2 * RANDOM_ITEMS / 3) drain_results();   // sender waits for all results
      if (burst_left > 0) begin
        burst_left--;
      end else if ($urandom_range(0, 49) == 0) begin
        burst_left = $urandom_range(30, 80);
      end else begin
        idle_sender(pick_gap());
      end
      send_row(make_random_row());
    end

    drain_results();
    repeat (8) @(posedge clk);   // catch any stray result after the last one
    if (mismatch_count == 0)
      $display("buffer_ring_fill_manager_core verification clean");
    else
      $display("buffer_ring_fill_manager_core verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/brfm_pkg.sv
hw/rtl/brfm_ram.sv
hw/rtl/brfm_exec.sv
hw/rtl/buffer_ring_fill_manager_core.sv
tb/sv/tb_buffer_ring_fill_manager_core.sv
